// ----- design/afd_pkg.sv -----
// shared types, constants and tables for the anchor-free detection decode unit
// no dependencies; used by every module of the block

package afd_pkg;

   // default values for the top level parameters
   localparam int MAX_CLASSES_DEF          = 128;
   localparam int SMALLEST_STRIDE_LOG2_DEF = 3;
   localparam int NUM_LEVELS_DEF           = 3;

   // fixed storage widths, sized for the full parameter range
   localparam int FIDX_W   = 9;   // up to 5 + 256 fields per row
   localparam int CLS_W    = 8;   // class index up to 255
   localparam int GRID_W   = 10;  // grid column and row, 0..1023
   localparam int LVL_W    = 2;   // up to four stride levels
   localparam int SCORE_W  = 16;
   localparam int CENTER_W = 22;  // q5.10 offset plus cell * 1024

   // field positions within one row
   localparam logic [FIDX_W-1:0] FIELD_CX   = 9'd0;
   localparam logic [FIDX_W-1:0] FIELD_CY   = 9'd1;
   localparam logic [FIDX_W-1:0] FIELD_LW   = 9'd2;
   localparam logic [FIDX_W-1:0] FIELD_LH   = 9'd3;
   localparam logic [FIDX_W-1:0] FIELD_OBJ  = 9'd4;
   localparam logic [FIDX_W-1:0] FIELD_CLS0 = 9'd5;

   localparam logic signed [15:0] LOG2E_Q14   = 16'sd23637;
   localparam logic [16:0]        CONF_MAX    = 17'd65536;
   localparam logic [18:0]        SIZE_MAX_Q4 = 19'h7FFFF;
   localparam int                 POS_MAX_Q4  = 524287;
   localparam int                 POS_MIN_Q4  = -524288;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_NUM_CLASSES     = 2'd0,
      CSR_SCORE_THRESHOLD = 2'd1,
      CSR_FRAME_ROWS      = 2'd2,
      CSR_FRAME_COLS      = 2'd3
   } csr_index_type;

   localparam logic [7:0]  NUM_CLASSES_RST = 8'd80;
   localparam logic [16:0] THRESHOLD_RST   = 17'd19661;
   localparam logic [12:0] FRAME_ROWS_RST  = 13'd640;
   localparam logic [12:0] FRAME_COLS_RST  = 13'd640;

   // one finished row, handed from the accumulator to the decode pipeline
   typedef struct packed {
      logic [SCORE_W-1:0] cx;
      logic [SCORE_W-1:0] cy;
      logic [SCORE_W-1:0] lw;
      logic [SCORE_W-1:0] lh;
      logic [SCORE_W-1:0] obj;
      logic [SCORE_W-1:0] best;
      logic [CLS_W-1:0]   cls;
      logic [GRID_W-1:0]  col;
      logic [GRID_W-1:0]  row;
      logic [LVL_W-1:0]   lvl;
   } row_tok_type;

   // decoded box
   typedef struct packed {
      logic [16:0] conf;
      logic [6:0]  label;
      logic [18:0] height;
      logic [18:0] width;
      logic [19:0] top;
      logic [19:0] left;
   } box_type;

   // pipeline status from the decode pipeline
   typedef struct packed {
      logic mul_rdy;
      logic mant_vld;
   } dec_stat_type;

   // 2^(i/16) in q16, entries 0..16
   function automatic logic [17:0] pow2_frac(input logic [4:0] i);
      logic [17:0] r;
      case (i)
         5'd0:    r = 18'd65536;
         5'd1:    r = 18'd68438;
         5'd2:    r = 18'd71468;
         5'd3:    r = 18'd74632;
         5'd4:    r = 18'd77936;
         5'd5:    r = 18'd81386;
         5'd6:    r = 18'd84990;
         5'd7:    r = 18'd88752;
         5'd8:    r = 18'd92682;
         5'd9:    r = 18'd96785;
         5'd10:   r = 18'd101070;
         5'd11:   r = 18'd105545;
         5'd12:   r = 18'd110218;
         5'd13:   r = 18'd115098;
         5'd14:   r = 18'd120194;
         5'd15:   r = 18'd125515;
         default: r = 18'd131072;
      endcase
      return r;
   endfunction

   // grid size of one level, clamped to 1..1024
   function automatic logic [10:0] grid_dim(input logic [12:0] frame, input logic [3:0] s);
      logic [12:0] d;
      d = frame >> s;
      if (d == 13'd0) begin
         return 11'd1;
      end
      if (d > 13'd1024) begin
         return 11'd1024;
      end
      return 11'(d);
   endfunction

endpackage

// ----- design/afd_accum.sv -----
// row accumulator: keeps box terms, objectness and class argmax, steps the grid
// uses afd_pkg; emits one row_tok_type word per finished row

module afd_accum #(
   parameter int MAX_CLASSES          = afd_pkg::MAX_CLASSES_DEF,
   parameter int SMALLEST_STRIDE_LOG2 = afd_pkg::SMALLEST_STRIDE_LOG2_DEF,
   parameter int NUM_LEVELS           = afd_pkg::NUM_LEVELS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [7:0]                 num_classes,
   input  logic [12:0]                frame_rows,
   input  logic [12:0]                frame_cols,
   input  logic                       accept,
   input  logic [afd_pkg::SCORE_W-1:0] score,
   input  logic                       frame_start,
   input  logic                       tok_take,
   output afd_pkg::row_tok_type       tok,
   output logic                       tok_vld
);

   logic [afd_pkg::FIDX_W-1:0]  field_ff, field_in;
   logic [afd_pkg::GRID_W-1:0]  col_ff, col_in, row_ff, row_in;
   logic [afd_pkg::LVL_W-1:0]   lvl_ff, lvl_in;
   logic [afd_pkg::SCORE_W-1:0] cx_ff, cx_in, cy_ff, cy_in, lw_ff, lw_in, lh_ff, lh_in;
   logic [afd_pkg::SCORE_W-1:0] obj_ff, obj_in, best_ff, best_in;
   logic [afd_pkg::CLS_W-1:0]   cls_ff, cls_in;
   logic                        tok_vld_ff, tok_vld_in;
   afd_pkg::row_tok_type        tok_ff, tok_in;

   logic [afd_pkg::FIDX_W-1:0]  fi, last;
   logic [8:0]                  nc;
   logic [afd_pkg::GRID_W-1:0]  col_cur, row_cur;
   logic [afd_pkg::LVL_W-1:0]   lvl_cur;
   logic [3:0]                  s;
   logic [10:0]                 col_nxt, row_nxt, dim_c, dim_r;
   logic                        row_end;

   always_comb begin
      nc = {1'b0, num_classes};
      if (nc == 9'd0) begin
         nc = 9'd1;
      end
      if (nc > 9'(MAX_CLASSES)) begin
         nc = 9'(MAX_CLASSES);
      end
      last = nc + (afd_pkg::FIELD_CLS0 - 9'd1);

      // frame start restarts the row and the grid walk before this word
      fi      = frame_start ? '0 : field_ff;
      col_cur = frame_start ? '0 : col_ff;
      row_cur = frame_start ? '0 : row_ff;
      lvl_cur = frame_start ? '0 : lvl_ff;
      if (fi > last) begin
         fi = '0;
      end

      cx_in   = cx_ff;
      cy_in   = cy_ff;
      lw_in   = lw_ff;
      lh_in   = lh_ff;
      obj_in  = obj_ff;
      best_in = best_ff;
      cls_in  = cls_ff;
      case (fi)
         afd_pkg::FIELD_CX:  cx_in  = score;
         afd_pkg::FIELD_CY:  cy_in  = score;
         afd_pkg::FIELD_LW:  lw_in  = score;
         afd_pkg::FIELD_LH:  lh_in  = score;
         afd_pkg::FIELD_OBJ: obj_in = score;
         default: begin
            // strict greater keeps the first maximum
            if (fi == afd_pkg::FIELD_CLS0 || $signed(score) > $signed(best_ff)) begin
               best_in = score;
               cls_in  = afd_pkg::CLS_W'(fi - afd_pkg::FIELD_CLS0);
            end
         end
      endcase

      row_end  = (fi == last);
      field_in = row_end ? '0 : fi + 9'd1;

      s       = 4'(SMALLEST_STRIDE_LOG2) + 4'(lvl_cur);
      dim_c   = afd_pkg::grid_dim(frame_cols, s);
      dim_r   = afd_pkg::grid_dim(frame_rows, s);
      col_nxt = 11'(col_cur) + 11'd1;
      row_nxt = 11'(row_cur) + 11'd1;
      col_in  = col_cur;
      row_in  = row_cur;
      lvl_in  = lvl_cur;
      if (row_end) begin
         if (col_nxt >= dim_c) begin
            col_in = '0;
            if (row_nxt >= dim_r) begin
               row_in = '0;
               if (3'(lvl_cur) + 3'd1 >= 3'(NUM_LEVELS)) begin
                  lvl_in = '0;
               end else begin
                  lvl_in = lvl_cur + 2'd1;
               end
            end else begin
               row_in = afd_pkg::GRID_W'(row_nxt);
            end
         end else begin
            col_in = afd_pkg::GRID_W'(col_nxt);
         end
      end

      tok_in.cx   = cx_in;
      tok_in.cy   = cy_in;
      tok_in.lw   = lw_in;
      tok_in.lh   = lh_in;
      tok_in.obj  = obj_in;
      tok_in.best = best_in;
      tok_in.cls  = cls_in;
      tok_in.col  = col_cur;
      tok_in.row  = row_cur;
      tok_in.lvl  = lvl_cur;

      tok_vld_in = tok_vld_ff && !tok_take;
      if (accept && row_end) begin
         tok_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         field_ff   <= '0;
         col_ff     <= '0;
         row_ff     <= '0;
         lvl_ff     <= '0;
         tok_vld_ff <= 1'b0;
      end else begin
         tok_vld_ff <= tok_vld_in;
         if (accept) begin
            field_ff <= field_in;
            col_ff   <= col_in;
            row_ff   <= row_in;
            lvl_ff   <= lvl_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cx_ff   <= cx_in;
         cy_ff   <= cy_in;
         lw_ff   <= lw_in;
         lh_ff   <= lh_in;
         obj_ff  <= obj_in;
         best_ff <= best_in;
         cls_ff  <= cls_in;
         if (row_end) begin
            tok_ff <= tok_in;
         end
      end
   end

   assign tok     = tok_ff;
   assign tok_vld = tok_vld_ff;

endmodule

// ----- design/afd_exp_mant.sv -----
// exp mantissa: splits a q24 base-2 exponent into integer part and
// interpolated 2^frac mantissa in q16; uses afd_pkg::pow2_frac

module afd_exp_mant (
   input  logic signed [31:0] y,
   output logic [17:0]        mant,
   output logic signed [7:0]  ip
);

   logic [3:0]  idx;
   logic [7:0]  wgt;
   logic [17:0] lo, hi;
   logic [12:0] step;
   logic [20:0] prod;

   always_comb begin
      // y stays within 32 bits, so the top byte is floor(y / 2^24)
      ip   = y[31:24];
      idx  = y[23:20];
      wgt  = y[19:12];
      lo   = afd_pkg::pow2_frac({1'b0, idx});
      hi   = afd_pkg::pow2_frac(5'({1'b0, idx}) + 5'd1);
      step = 13'(hi - lo);
      prod = 21'(step) * 21'(wgt);
      mant = lo + 18'(prod >> 8);
   end

endmodule

// ----- design/afd_exp_scale.sv -----
// exp scaling: mantissa times 2^(ip + s - 12), saturated to the 19-bit size range
// uses afd_pkg constants

module afd_exp_scale (
   input  logic [17:0]       mant,
   input  logic signed [7:0] ip,
   input  logic [3:0]        s,
   output logic [18:0]       size
);

   logic signed [9:0] e;
   logic [19:0]       up;
   logic [4:0]        nsh;

   always_comb begin
      e   = 10'(ip) + 10'(s) - 10'sd12;
      up  = 20'(mant) << e[1:0];
      nsh = 5'(-e);
      if (e >= 10'sd3) begin
         size = afd_pkg::SIZE_MAX_Q4;
      end else if (e >= 10'sd0) begin
         size = (up > 20'(afd_pkg::SIZE_MAX_Q4)) ? afd_pkg::SIZE_MAX_Q4 : 19'(up);
      end else if (e <= -10'sd18) begin
         size = '0;
      end else begin
         size = 19'(mant >> nsh);
      end
   end

endmodule

// ----- design/afd_decode.sv -----
// decode pipeline: products, confidence test, exp mantissa, then box geometry
// uses afd_pkg, afd_exp_mant and afd_exp_scale

module afd_decode #(
   parameter int SMALLEST_STRIDE_LOG2 = afd_pkg::SMALLEST_STRIDE_LOG2_DEF,
   parameter int NUM_LEVELS           = afd_pkg::NUM_LEVELS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [16:0]           score_threshold,
   input  afd_pkg::row_tok_type  tok,
   input  logic                  tok_vld,
   input  logic                  out_rdy,
   output afd_pkg::box_type      box,
   output afd_pkg::dec_stat_type stat
);

   localparam int S_MAX  = SMALLEST_STRIDE_LOG2 + NUM_LEVELS - 1;
   localparam int CPOS_W = afd_pkg::CENTER_W + S_MAX;

   // multiply stage
   logic                               mul_vld_ff, mul_vld_in;
   logic signed [31:0]                 p_ff, p_in, yw_ff, yw_in, yh_ff, yh_in;
   logic signed [afd_pkg::CENTER_W-1:0] vx_ff, vx_in, vy_ff, vy_in;
   logic [afd_pkg::CLS_W-1:0]          mcls_ff;
   logic [afd_pkg::LVL_W-1:0]          mlvl_ff;

   // mantissa stage
   logic                     mant_vld_ff, mant_vld_in;
   logic [17:0]              mw_ff, mw_in, mh_ff, mh_in;
   logic signed [7:0]        ipw_ff, ipw_in, iph_ff, iph_in;
   logic signed [CPOS_W-1:0] px_ff, px_in, py_ff, py_in;
   logic [16:0]              conf_ff, conf_in;
   logic [afd_pkg::CLS_W-1:0] cls_ff;
   logic [3:0]               s_ff, s_in;

   logic                     mul_rdy, mant_rdy, keep;
   logic signed [15:0]       best_s, obj_s, lw_s, lh_s, cx_s, cy_s;
   logic signed [CPOS_W-1:0] wx, wy;
   logic [18:0]              w, h;
   logic signed [CPOS_W:0]   dl, dt;

   assign mant_rdy = !mant_vld_ff || out_rdy;
   assign mul_rdy  = !mul_vld_ff || mant_rdy;

   always_comb begin
      best_s = tok.best;
      obj_s  = tok.obj;
      lw_s   = tok.lw;
      lh_s   = tok.lh;
      cx_s   = tok.cx;
      cy_s   = tok.cy;
      p_in   = best_s * obj_s;
      yw_in  = lw_s * afd_pkg::LOG2E_Q14;
      yh_in  = lh_s * afd_pkg::LOG2E_Q14;
      vx_in  = afd_pkg::CENTER_W'(cx_s) + afd_pkg::CENTER_W'({tok.col, 10'd0});
      vy_in  = afd_pkg::CENTER_W'(cy_s) + afd_pkg::CENTER_W'({tok.row, 10'd0});
      mul_vld_in = mul_rdy ? tok_vld : mul_vld_ff;
   end

   always_comb begin
      // negative product gives zero, q10.20 down to q0.16 with clamp
      if (p_ff[31]) begin
         conf_in = '0;
      end else if (p_ff[31:4] > 28'(afd_pkg::CONF_MAX)) begin
         conf_in = afd_pkg::CONF_MAX;
      end else begin
         conf_in = 17'(p_ff[31:4]);
      end
      keep = conf_in >= score_threshold;
      s_in = 4'(SMALLEST_STRIDE_LOG2) + 4'(mlvl_ff);
      wx   = CPOS_W'(vx_ff);
      wy   = CPOS_W'(vy_ff);
      px_in = (wx <<< s_in) >>> 6;
      py_in = (wy <<< s_in) >>> 6;
      mant_vld_in = mant_rdy ? (mul_vld_ff && keep) : mant_vld_ff;
   end

   afd_exp_mant u_mant_w (.y(yw_ff), .mant(mw_in), .ip(ipw_in));
   afd_exp_mant u_mant_h (.y(yh_ff), .mant(mh_in), .ip(iph_in));

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_vld_ff  <= 1'b0;
         mant_vld_ff <= 1'b0;
      end else begin
         mul_vld_ff  <= mul_vld_in;
         mant_vld_ff <= mant_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mul_rdy && tok_vld) begin
         p_ff    <= p_in;
         yw_ff   <= yw_in;
         yh_ff   <= yh_in;
         vx_ff   <= vx_in;
         vy_ff   <= vy_in;
         mcls_ff <= tok.cls;
         mlvl_ff <= tok.lvl;
      end
      if (mant_rdy && mul_vld_ff) begin
         mw_ff   <= mw_in;
         mh_ff   <= mh_in;
         ipw_ff  <= ipw_in;
         iph_ff  <= iph_in;
         px_ff   <= px_in;
         py_ff   <= py_in;
         conf_ff <= conf_in;
         cls_ff  <= mcls_ff;
         s_ff    <= s_in;
      end
   end

   afd_exp_scale u_scale_w (.mant(mw_ff), .ip(ipw_ff), .s(s_ff), .size(w));
   afd_exp_scale u_scale_h (.mant(mh_ff), .ip(iph_ff), .s(s_ff), .size(h));

   always_comb begin
      dl = (CPOS_W+1)'(px_ff) - (CPOS_W+1)'(w[18:1]);
      dt = (CPOS_W+1)'(py_ff) - (CPOS_W+1)'(h[18:1]);
      if (dl > (CPOS_W+1)'(afd_pkg::POS_MAX_Q4)) begin
         box.left = 20'(afd_pkg::POS_MAX_Q4);
      end else if (dl < (CPOS_W+1)'(afd_pkg::POS_MIN_Q4)) begin
         box.left = 20'(afd_pkg::POS_MIN_Q4);
      end else begin
         box.left = 20'(dl);
      end
      if (dt > (CPOS_W+1)'(afd_pkg::POS_MAX_Q4)) begin
         box.top = 20'(afd_pkg::POS_MAX_Q4);
      end else if (dt < (CPOS_W+1)'(afd_pkg::POS_MIN_Q4)) begin
         box.top = 20'(afd_pkg::POS_MIN_Q4);
      end else begin
         box.top = 20'(dt);
      end
      box.width  = w;
      box.height = h;
      box.label  = 7'(cls_ff);
      box.conf   = conf_ff;
   end

   assign stat.mul_rdy  = mul_rdy;
   assign stat.mant_vld = mant_vld_ff;

endmodule

// ----- design/anchor_free_detection_decode_unit.sv -----
// top level of the anchor-free detection head decoder
// uses afd_pkg, afd_accum, afd_decode
//
//   channel | dir | handshake          | payload
//   req_    | in  | tvalid/tready      | tdata: score_value q5.10, tuser: frame_start
//   rsp_    | out | tvalid/tready      | tdata: left, top, width, height, label, confidence
//   csr_    | in  | wr_en, no wait     | addr selects register, wr_data
//
// one head word is taken per cycle while the result side keeps up
// a box passes from the last word of its row through the row register, multiply
// stage, mantissa stage and output register
// rows below threshold drop out at the mantissa stage and never reach the output
// a stall on rsp_tready backs up through the stages and then drops req_tready
// synchronous reset returns registers to defaults and the grid walk to level 0

module anchor_free_detection_decode_unit #(
   parameter int MAX_CLASSES          = afd_pkg::MAX_CLASSES_DEF,
   parameter int SMALLEST_STRIDE_LOG2 = afd_pkg::SMALLEST_STRIDE_LOG2_DEF,
   parameter int NUM_LEVELS           = afd_pkg::NUM_LEVELS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [15:0]   req_tdata,   // [15:0] score_value
   input  logic          req_tuser,   // [0] frame_start
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // [19:0] box_left, [39:20] box_top, [58:40] box_width, [77:59] box_height,
   // [84:78] class_label, [101:85] confidence, [103:102] zero
   output logic [103:0]  rsp_tdata,
   input  logic          csr_wr_en,
   input  logic [1:0]    csr_addr,
   input  logic [16:0]   csr_wr_data
);

   logic [7:0]  num_classes_ff;
   logic [16:0] threshold_ff;
   logic [12:0] frame_rows_ff, frame_cols_ff;

   logic                  accept, tok_vld, out_rdy;
   afd_pkg::row_tok_type  tok;
   afd_pkg::box_type      box, box_ff;
   afd_pkg::dec_stat_type stat;
   logic                  rsp_vld_ff, rsp_vld_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_classes_ff <= afd_pkg::NUM_CLASSES_RST;
         threshold_ff   <= afd_pkg::THRESHOLD_RST;
         frame_rows_ff  <= afd_pkg::FRAME_ROWS_RST;
         frame_cols_ff  <= afd_pkg::FRAME_COLS_RST;
      end else if (csr_wr_en) begin
         case (csr_addr)
            afd_pkg::CSR_NUM_CLASSES:     num_classes_ff <= csr_wr_data[7:0];
            afd_pkg::CSR_SCORE_THRESHOLD: threshold_ff   <= csr_wr_data;
            afd_pkg::CSR_FRAME_ROWS:      frame_rows_ff  <= csr_wr_data[12:0];
            afd_pkg::CSR_FRAME_COLS:      frame_cols_ff  <= csr_wr_data[12:0];
            default: ;
         endcase
      end
   end

   // the row register frees up whenever the multiply stage can take it
   assign req_tready = !tok_vld || stat.mul_rdy;
   assign accept     = req_tvalid && req_tready;
   assign out_rdy    = !rsp_vld_ff || rsp_tready;

   afd_accum #(
      .MAX_CLASSES(MAX_CLASSES),
      .SMALLEST_STRIDE_LOG2(SMALLEST_STRIDE_LOG2),
      .NUM_LEVELS(NUM_LEVELS)
   ) u_accum (
      .clock(clock),
      .reset(reset),
      .num_classes(num_classes_ff),
      .frame_rows(frame_rows_ff),
      .frame_cols(frame_cols_ff),
      .accept(accept),
      .score(req_tdata),
      .frame_start(req_tuser),
      .tok_take(stat.mul_rdy),
      .tok(tok),
      .tok_vld(tok_vld)
   );

   afd_decode #(
      .SMALLEST_STRIDE_LOG2(SMALLEST_STRIDE_LOG2),
      .NUM_LEVELS(NUM_LEVELS)
   ) u_decode (
      .clock(clock),
      .reset(reset),
      .score_threshold(threshold_ff),
      .tok(tok),
      .tok_vld(tok_vld),
      .out_rdy(out_rdy),
      .box(box),
      .stat(stat)
   );

   assign rsp_vld_in = out_rdy ? stat.mant_vld : rsp_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_rdy && stat.mant_vld) begin
         box_ff <= box;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {2'b00, box_ff.conf, box_ff.label, box_ff.height, box_ff.width,
                        box_ff.top, box_ff.left};

   // a finished row waiting on the multiply stage is never lost
   a_tok_held : assert property (@(posedge clock) disable iff (reset)
      tok_vld && !stat.mul_rdy |=> tok_vld)
      else $error("row word dropped while multiply stage stalled");

   // a box waiting behind a full output register stays in the mantissa stage
   a_mant_held : assert property (@(posedge clock) disable iff (reset)
      stat.mant_vld && rsp_vld_ff && !rsp_tready |=> stat.mant_vld)
      else $error("box dropped while output stalled");

   // confidence never exceeds one in q0.16
   a_conf_range : assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> box_ff.conf <= afd_pkg::CONF_MAX)
      else $error("confidence out of range");

endmodule
